### hdl/crle_pkg.sv
// Package for the console receive line editor.
// Holds the FIFO geometry, command and result codes and the result record.
// No dependencies; every other file imports it.
package crle_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;

    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
    localparam logic [7:0] KEY_SPACE     = 8'h20;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_START   = 2'd1,
        CMD_SERVICE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_RSVD  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_out;
        logic [15:0] position;
        logic        last;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input item taken this cycle
        logic eval;     // edit the line with the fetched character
        logic pop;      // result item taken this cycle
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic svc_ok;     // read active and FIFO not empty
        logic zero_count; // start request carries count 0
        logic eval_res;   // the fetched character gives results
        logic head_last;  // result at the head is the final one
    } t_dp_status;

endpackage

### hdl/crle_if.sv
// Channel interfaces for the console receive line editor.
// Depends on crle_pkg for field types.
interface crle_in_if;
    import crle_pkg::*;
    logic        valid;
    logic        ready;
    t_cmd_code   cmd;
    logic [7:0]  ch;
    logic [15:0] count;

    modport source (output valid, cmd, ch, count, input ready);
    modport sink   (input valid, cmd, ch, count, output ready);
endinterface

interface crle_out_if;
    import crle_pkg::*;
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [7:0]  byte_out;
    logic [15:0] position;
    logic        last;

    modport source (output valid, kind, byte_out, position, last, input ready);
    modport sink   (input valid, kind, byte_out, position, last, output ready);
endinterface

### hdl/crle_ctrl.sv
// Controller state machine of the console receive line editor.
// Depends on crle_pkg; drives the handshakes and sequences the datapath.
module crle_ctrl
    import crle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_cmd_code  i_in_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   in_fire, out_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_fire     = o_in_ready & i_in_valid;
    assign out_fire    = o_out_valid & i_out_ready;

    assign o_cmd.accept = in_fire;
    assign o_cmd.eval   = (r_state == S_EVAL);
    assign o_cmd.pop    = out_fire;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_cmd)
                        CMD_START:   if (i_status.zero_count) n_state = S_EMIT;
                        CMD_SERVICE: if (i_status.svc_ok) n_state = S_EVAL;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_EVAL: n_state = i_status.eval_res ? S_EMIT : S_IDLE;
            S_EMIT: if (out_fire && i_status.head_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/crle_dp.sv
// Datapath of the console receive line editor: FIFO memory, pointers,
// line state and the result queue. Depends on crle_pkg.
module crle_dp
    import crle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd_code   i_code,
    input  logic [7:0]  i_ch,
    input  logic [15:0] i_count,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output t_result     o_result
);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, wr_next, rd_next;
    logic             r_active;
    logic [15:0]      r_limit, r_len, len_inc;
    t_result          r_q [3];
    logic [1:0]       r_head;
    logic             full, do_push, do_pop, is_bs, done;

    assign wr_next = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign full    = (wr_next == r_rd_ptr);
    assign do_push = i_cmd.accept && (i_code == CMD_PUSH) && !full;
    assign do_pop  = i_cmd.accept && (i_code == CMD_SERVICE) && o_status.svc_ok;

    assign is_bs   = (r_rd_data == KEY_BACKSPACE);
    assign len_inc = r_len + 16'd1;
    assign done    = (r_rd_data == KEY_NEWLINE) || (len_inc >= r_limit);

    assign o_status.svc_ok     = r_active && (r_rd_ptr != r_wr_ptr);
    assign o_status.zero_count = (i_count == 16'd0);
    assign o_status.eval_res   = !(is_bs && (r_len == 16'd0));
    assign o_status.head_last  = r_q[r_head].last;
    assign o_result            = r_q[r_head];

    // FIFO memory: write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_ch;
        end
        if (do_pop) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    // Result queue payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_code == CMD_START)) begin
            r_q[0] <= '{kind: KIND_DONE, byte_out: 8'd0, position: 16'd0, last: 1'b1};
        end else if (i_cmd.eval) begin
            if (is_bs) begin
                r_q[0] <= '{kind: KIND_ECHO, byte_out: KEY_BACKSPACE, position: 16'd0,
                            last: 1'b0};
                r_q[1] <= '{kind: KIND_ECHO, byte_out: KEY_SPACE, position: 16'd0,
                            last: 1'b0};
                r_q[2] <= '{kind: KIND_ECHO, byte_out: KEY_BACKSPACE, position: 16'd0,
                            last: 1'b1};
            end else begin
                r_q[0] <= '{kind: KIND_STORE, byte_out: r_rd_data, position: r_len,
                            last: 1'b0};
                r_q[1] <= '{kind: KIND_ECHO, byte_out: r_rd_data, position: 16'd0,
                            last: !done};
                r_q[2] <= '{kind: KIND_DONE, byte_out: 8'd0, position: len_inc,
                            last: 1'b1};
            end
        end
    end

    // Pointers and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_active <= 1'b0;
            r_limit  <= '0;
            r_len    <= '0;
            r_head   <= '0;
        end else begin
            if (do_push) r_wr_ptr <= wr_next;
            if (do_pop)  r_rd_ptr <= rd_next;
            if (i_cmd.accept && (i_code == CMD_START)) begin
                r_len    <= '0;
                r_limit  <= i_count;
                r_active <= (i_count != 16'd0);
                r_head   <= '0;
            end
            if (i_cmd.eval) begin
                r_head <= '0;
                if (is_bs) begin
                    if (r_len != 16'd0) r_len <= r_len - 16'd1;
                end else begin
                    r_len <= len_inc;
                    if (done) r_active <= 1'b0;
                end
            end
            if (i_cmd.pop) r_head <= r_head + 2'd1;
        end
    end

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_head != 2'd3))
        else $error("result queue head out of range");
    a_active_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_limit != 16'd0))
        else $error("read active with zero limit");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_len < r_limit))
        else $error("line length reached limit while read active");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |-> (r_rd_ptr != r_wr_ptr))
        else $error("pop from empty FIFO");

endmodule

### hdl/console_rx_fifo_line_editor.sv
// Top level of the console receive path with a canonical line editor.
// Depends on crle_pkg, crle_if, crle_ctrl and crle_dp.
//
// Use: one input channel (i_in) carries items with cmd, ch and count;
// one output channel (o_out) carries result items with kind, byte_out,
// position and last. Both use valid/ready; an item moves when both are high.
//  - push (cmd 0): store ch in the receive FIFO, no result;
//    dropped silently when the FIFO already holds FIFO_DEPTH-1 characters.
//  - start (cmd 1): begin a read of up to count bytes; a count of
//    zero gives one completion item in the next cycle.
//  - service (cmd 2): pop one character when a read is active and the
//    FIFO is not empty, then edit the line; after the accept cycle the FIFO
//    read data is registered, an evaluate state builds up to three results,
//    then one result item leaves per cycle while the receiver is ready.
// The block handles one item at a time: ready is low from the cycle after a
// popping service or zero-count start until the final result, if any, is taken.
// When the receiver stalls, the head result holds and nothing is accepted.
// Reset (synchronous, active low) empties the FIFO, ends any read and clears
// the line; FIFO contents need no clearing as only written entries are read.
module console_rx_fifo_line_editor
    import crle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    crle_in_if.sink    i_in,
    crle_out_if.source o_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_result    result;

    // Sequence the handshakes
    crle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Hold the FIFO, the line state and the result queue
    crle_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_code   (i_in.cmd),
        .i_ch     (i_in.ch),
        .i_count  (i_in.count),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_result (result)
    );

    assign o_out.kind     = result.kind;
    assign o_out.byte_out = result.byte_out;
    assign o_out.position = result.position;
    assign o_out.last     = result.last;

endmodule

### verif/console_rx_fifo_line_editor_test.sv
// Self-checking test of the console receive line editor: a stimulus table, then random
// typing sessions, a FIFO fill and drain, all scored against a line discipline predictor.
// Depends on crle_pkg, the crle_in_if/crle_out_if channels and console_rx_fifo_line_editor.
module console_rx_fifo_line_editor_test;
    import crle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, counted by the receiver
    localparam int TAIL_CYCLES  = 20;    // quiet time after the last result
    localparam int RANDOM_A     = 40;    // effective items before the fill and drain phase
    localparam int DRAIN_SVC    = 30;    // service items offered against the full FIFO
    localparam int SESSIONS_B   = 2;     // typing sessions after the fill and drain phase

    localparam t_result NO_RES = '0;
    // Rubout on a non-empty line: backspace, space, backspace.
    localparam t_result [0:2] RUBOUT = {
        t_result'{KIND_ECHO, KEY_BACKSPACE, 16'd0, 1'b0},
        t_result'{KIND_ECHO, KEY_SPACE,     16'd0, 1'b0},
        t_result'{KIND_ECHO, KEY_BACKSPACE, 16'd0, 1'b1}};

    // One row of the directed table; n_fixed > 0 means the expected results are typed in.
    typedef struct packed {
        t_cmd_code     cmd;
        logic [7:0]    ch;
        logic [15:0]   count;
        logic [1:0]    n_fixed;
        t_result [0:2] fixed;
    } t_stim_row;

    localparam int N_ROWS = 25;

    t_stim_row directed_rows [0:N_ROWS-1] = '{
        // service before any read: nothing popped
        '{CMD_SERVICE, 8'h00, 16'd0,      2'd0, {3{NO_RES}}},
        // zero count: completes at once with length 0
        '{CMD_START,   8'h00, 16'd0,      2'd1,
          {t_result'{KIND_DONE, 8'h00, 16'd0, 1'b1}, NO_RES, NO_RES}},
        // unused command code
        '{CMD_NONE,    8'hFF, 16'hFFFF,   2'd0, {3{NO_RES}}},
        '{CMD_PUSH,    8'h00, 16'hFFFF,   2'd0, {3{NO_RES}}},
        '{CMD_PUSH,    8'hFF, 16'h0000,   2'd0, {3{NO_RES}}},
        '{CMD_START,   8'hFF, 16'hFFFF,   2'd0, {3{NO_RES}}},
        '{CMD_SERVICE, 8'h00, 16'd0,      2'd0, {3{NO_RES}}},
        '{CMD_SERVICE, 8'hFF, 16'hFFFF,   2'd0, {3{NO_RES}}},
        // FIFO empty while the read is active
        '{CMD_SERVICE, 8'h00, 16'd0,      2'd0, {3{NO_RES}}},
        '{CMD_PUSH,    KEY_BACKSPACE, 16'd0, 2'd0, {3{NO_RES}}},
        '{CMD_PUSH,    KEY_BACKSPACE, 16'd0, 2'd0, {3{NO_RES}}},
        '{CMD_PUSH,    KEY_BACKSPACE, 16'd0, 2'd0, {3{NO_RES}}},
        '{CMD_SERVICE, 8'h00, 16'd0,      2'd3, RUBOUT},
        '{CMD_SERVICE, 8'h00, 16'd0,      2'd0, {3{NO_RES}}},
        // backspace on an empty line: consumed silently
        '{CMD_SERVICE, 8'h00, 16'd0,      2'd0, {3{NO_RES}}},
        '{CMD_PUSH,    8'h78, 16'd0,      2'd0, {3{NO_RES}}},
        // restart while a read is active, count of one
        '{CMD_START,   8'h00, 16'd1,      2'd0, {3{NO_RES}}},
        '{CMD_SERVICE, 8'h00, 16'd0,      2'd3,
          {t_result'{KIND_STORE, 8'h78, 16'd0, 1'b0},
           t_result'{KIND_ECHO,  8'h78, 16'd0, 1'b0},
           t_result'{KIND_DONE,  8'h00, 16'd1, 1'b1}}},
        '{CMD_PUSH,    KEY_NEWLINE, 16'd0, 2'd0, {3{NO_RES}}},
        '{CMD_START,   8'h00, 16'd5,      2'd0, {3{NO_RES}}},
        // newline ends the line before the count
        '{CMD_SERVICE, 8'h00, 16'd0,      2'd0, {3{NO_RES}}},
        '{CMD_START,   8'h00, 16'd3,      2'd0, {3{NO_RES}}},
        '{CMD_START,   8'h00, 16'hFFFF,   2'd0, {3{NO_RES}}},
        '{CMD_PUSH,    8'h55, 16'hAAAA,   2'd0, {3{NO_RES}}},
        '{CMD_SERVICE, 8'hAA, 16'h5555,   2'd0, {3{NO_RES}}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    crle_in_if  in_ch ();
    crle_out_if out_ch ();

    console_rx_fifo_line_editor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the key FIFO and the line being edited.
    // ------------------------------------------------------------------
    logic [7:0]  key_fifo [FIFO_DEPTH];
    int          key_wr = 0;
    int          key_rd = 0;
    bit          line_open = 1'b0;
    logic [15:0] line_max = '0;
    logic [15:0] line_len = '0;

    t_result pending_results [$];
    int      mismatches      = 0;
    int      effective_items = 0;  // accepted items that changed state or gave results
    int      offer_row       = -1; // directed row on offer, -1 for random items
    int      hold_asks       = 0;  // raised by the sender, served by the receiver
    int      holds_done      = 0;
    int      burst_left      = 0;
    bit      steady_sender   = 1'b0;
    int      cycle_count     = 0;

    // Work out the results of one accepted item and advance the line state.
    function automatic void line_discipline_step(
        input  t_cmd_code     cmd,
        input  logic [7:0]    ch,
        input  logic [15:0]   count,
        output t_result [0:2] res,
        output int            n,
        output bit            took
    );
        logic [7:0] c;
        n    = 0;
        took = 1'b1;
        res  = '0;
        case (cmd)
            CMD_PUSH: begin
                if ((key_wr + 1) % FIFO_DEPTH != key_rd) begin
                    key_fifo[key_wr] = ch;
                    key_wr = (key_wr + 1) % FIFO_DEPTH;
                end else begin
                    took = 1'b0;    // full: drop the key
                end
            end
            CMD_START: begin
                line_len  = '0;
                line_max  = count;
                line_open = (count != 16'd0);
                if (count == 16'd0) begin
                    res[0] = '{KIND_DONE, 8'h00, 16'd0, 1'b0};
                    n = 1;
                end
            end
            CMD_SERVICE: begin
                if (!line_open || key_rd == key_wr) begin
                    took = 1'b0;
                end else begin
                    c = key_fifo[key_rd];
                    key_rd = (key_rd + 1) % FIFO_DEPTH;
                    if (c == KEY_BACKSPACE) begin
                        if (line_len != 16'd0) begin
                            line_len = line_len - 16'd1;
                            res[0] = '{KIND_ECHO, KEY_BACKSPACE, 16'd0, 1'b0};
                            res[1] = '{KIND_ECHO, KEY_SPACE,     16'd0, 1'b0};
                            res[2] = '{KIND_ECHO, KEY_BACKSPACE, 16'd0, 1'b0};
                            n = 3;
                        end
                    end else begin
                        res[0] = '{KIND_STORE, c, line_len, 1'b0};
                        line_len = line_len + 16'd1;
                        res[1] = '{KIND_ECHO, c, 16'd0, 1'b0};
                        n = 2;
                        if (c == KEY_NEWLINE || line_len >= line_max) begin
                            line_open = 1'b0;
                            res[2] = '{KIND_DONE, 8'h00, line_len, 1'b0};
                            n = 3;
                        end
                    end
                end
            end
            default: took = 1'b0;
        endcase
        if (n > 0)
            res[n-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check result items first, then predict from the input
    // item taken at the same edge, so a same-edge pair never mixes up.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_result       got;
        t_result       want;
        t_result [0:2] res;
        int            n;
        bit            took;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.kind, out_ch.byte_out, out_ch.position, out_ch.last};
                if (pending_results.size() == 0) begin
                    $error("result item with none expected: kind %0d byte_out %02h position %0d",
                           got.kind, got.byte_out, got.position);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.byte_out !== want.byte_out) begin
                        $error("byte_out: expected %02h, got %02h", want.byte_out, got.byte_out);
                        mismatches++;
                    end
                    if (got.position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, got.position);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                line_discipline_step(in_ch.cmd, in_ch.ch, in_ch.count, res, n, took);
                if (took)
                    effective_items++;
                // Typed-in table rows stand in for the prediction; the state still advances.
                if (offer_row >= 0 && directed_rows[offer_row].n_fixed != 2'd0) begin
                    n   = directed_rows[offer_row].n_fixed;
                    res = directed_rows[offer_row].fixed;
                end
                for (int k = 0; k < n; k++)
                    pending_results.push_back(res[k]);
            end
        end
    end

    // Watchdog: give up well beyond the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall in phases of its own (always ready, random, two
    // fixed patterns), and serve a long hold-off whenever the sender asks.
    // ------------------------------------------------------------------
    initial begin : receiver
        int unsigned mode;
        int unsigned phase_left;
        int unsigned tick;
        mode       = 0;
        phase_left = 0;
        tick       = 0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_asks != holds_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 3);
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            tick++;
            case (mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 99) < 55);
                2:       out_ch.ready <= ((tick % 5) < 2);
                default: out_ch.ready <= ((tick % 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Work in bursts; between bursts drop valid for a random gap.
    task automatic pace();
        if (burst_left == 0) begin
            if (!steady_sender) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic offer(input t_cmd_code c, input logic [7:0] b, input logic [15:0] n,
                         input int row);
        pace();
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= c;
        in_ch.ch    <= b;
        in_ch.count <= n;
        offer_row   <= row;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering until every expected result item has arrived.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge i_clk);
        while (pending_results.size() != 0);
    endtask

    // One typing session: start a read, type ahead and service in a random mix,
    // with the odd stray command thrown in. Now and then skip the start.
    task automatic typing_session();
        int unsigned pick;
        int unsigned keys;
        int unsigned svc_left;
        int unsigned sel;
        logic [15:0] lim;
        logic [7:0]  key;
        steady_sender = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            lim = 16'($urandom_range(1, 8));
        else if (pick == 7)
            lim = 16'd0;
        else if (pick == 8)
            lim = 16'($urandom_range(9, 40));
        else
            lim = 16'($urandom);
        if ($urandom_range(0, 9) != 0)
            offer(CMD_START, 8'($urandom), lim, -1);
        keys     = $urandom_range(1, 10);
        svc_left = 0;
        repeat (keys) begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
                key = KEY_BACKSPACE;
            else if (sel < 18)
                key = KEY_NEWLINE;
            else if (sel < 22)
                key = sel[0] ? 8'hFF : 8'h00;
            else if (sel < 80)
                key = 8'($urandom_range(8'h20, 8'h7E));
            else
                key = 8'($urandom);
            offer(CMD_PUSH, key, 16'($urandom), -1);
            svc_left++;
            if ($urandom_range(0, 1) == 1) begin
                offer(CMD_SERVICE, 8'($urandom), 16'($urandom), -1);
                svc_left--;
            end
            if ($urandom_range(0, 19) == 0)
                offer(t_cmd_code'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), -1);
        end
        svc_left += $urandom_range(0, 2);
        repeat (svc_left)
            offer(CMD_SERVICE, 8'($urandom), 16'($urandom), -1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int mark;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = CMD_NONE;
        in_ch.ch     = '0;
        in_ch.count  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table.
        for (int r = 0; r < N_ROWS; r++)
            offer(directed_rows[r].cmd, directed_rows[r].ch, directed_rows[r].count, r);
        wait_drained();

        // Random typing sessions.
        mark = effective_items;
        while (effective_items - mark < RANDOM_A)
            typing_session();

        // Hold back until the block has said everything, then fill the FIFO past full.
        wait_drained();
        steady_sender = 1'b0;
        offer(CMD_START, 8'($urandom), 16'd0, -1);  // close any open read
        repeat (FIFO_DEPTH + 4)
            offer(CMD_PUSH, 8'($urandom), 16'($urandom), -1);

        // Drain a stretch with a long receiver hold-off at the start; reopen reads as
        // they end.
        hold_asks++;
        repeat (DRAIN_SVC) begin
            if (!line_open)
                offer(CMD_START, 8'($urandom), 16'($urandom_range(1, 64)), -1);
            offer(CMD_SERVICE, 8'($urandom), 16'($urandom), -1);
        end

        repeat (SESSIONS_B)
            typing_session();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/crle_pkg.sv
hdl/crle_if.sv
hdl/crle_ctrl.sv
hdl/crle_dp.sv
hdl/console_rx_fifo_line_editor.sv
verif/console_rx_fifo_line_editor_test.sv
